/* rtl/core/afw_pkg.sv */
// afw_pkg: shared constants, register and window codes for the audio frame window.
// Also holds the Q30 series constants used to fill the quarter-wave table.
// No dependencies.
package afw_pkg;

    // Parameter defaults
    localparam int MAX_FRAME_DEF       = 4096;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int COS_TABLE_DEPTH_DEF = 256;

    // Field and register widths
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 24;
    localparam int FRAME_LENGTH_W = 13;
    localparam int STEP_W         = 24;
    localparam int PHASE_W        = 24;
    localparam int RAMP_W         = 25;
    localparam int GAIN_W         = 17;  // Q1.16 gain, up to 1.0
    localparam int COS_W          = 18;  // signed Q1.16 cosine
    localparam int COEF_W         = 18;  // signed multiplier coefficient

    // Register reset values
    localparam logic [FRAME_LENGTH_W-1:0] FRAME_LENGTH_RST = 13'd1024;
    localparam logic [STEP_W-1:0]         PHASE_STEP_RST   = 24'd16400;
    localparam logic [STEP_W-1:0]         RAMP_STEP_RST    = 24'd32768;

    // Gain constants
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
    localparam logic [RAMP_W-1:0] RAMP_ONE = 25'h1000000;
    localparam logic [GAIN_W-1:0] HAMM_A   = 17'd35389;
    localparam logic [GAIN_W-1:0] HANN_A   = 17'd32768;
    localparam logic signed [COEF_W-1:0] HAMM_B_NEG = -18'sd30147;
    localparam logic signed [COEF_W-1:0] HANN_B_NEG = -18'sd32768;

    // Series constants, Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_KIND  = 2'd0,
        REG_FRAME_LENGTH = 2'd1,
        REG_PHASE_STEP   = 2'd2,
        REG_RAMP_STEP    = 2'd3
    } cfg_reg_t;

    // Window kinds
    typedef enum logic [1:0] {
        WIN_RECT     = 2'd0,
        WIN_BARTLETT = 2'd1,
        WIN_HAMMING  = 2'd2,
        WIN_HANN     = 2'd3
    } window_kind_t;

endpackage

/* rtl/core/audio_frame_window.sv */
// audio_frame_window: frame position tracking and window gain applied per sample.
// Depends on afw_pkg and afw_cos_rom.
//
//   channel   handshake                   payload
//   -------   -------------------------   --------------------------------
//   cfg       cfg_valid / cfg_ready       cfg_index, cfg_data
//   input     sample_valid / sample_ready sample
//   result    result_valid / result_ready windowed_sample, frame_end
//
// From acceptance to its word landing in the output register, a sample goes
// through one cosine table read, then the shared multiplier twice (cosine
// times coefficient, then sample times gain) with a gain add in between.
// A new sample is taken only once the sequencer is back in its idle step.
// cfg_ready is always high; registers take effect on the next sample.
// Reset (rst_n low, asynchronous) loads register defaults and clears the
// frame position, phase and ramp. A stalled result holds the sequencer in
// its final step until the output register frees.
module audio_frame_window #(
    parameter int MAX_FRAME       = afw_pkg::MAX_FRAME_DEF,
    parameter int SAMPLE_BITS     = afw_pkg::SAMPLE_BITS_DEF,
    parameter int COS_TABLE_DEPTH = afw_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [afw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [SAMPLE_BITS-1:0]     windowed_sample,
    output logic                              frame_end
);
    import afw_pkg::*;

    localparam int LEN_W  = ($clog2(MAX_FRAME + 1) > FRAME_LENGTH_W) ?
                            $clog2(MAX_FRAME + 1) : FRAME_LENGTH_W;
    localparam int POS_W  = $clog2(MAX_FRAME);
    localparam int MA_W   = (SAMPLE_BITS > COS_W) ? SAMPLE_BITS : COS_W;
    localparam int PROD_W = MA_W + COEF_W;
    localparam logic signed [PROD_W-1:0] SAT_TOP =
        PROD_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [PROD_W-1:0] SAT_BOT = ~SAT_TOP;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GMUL,
        ST_GAIN,
        ST_SMUL,
        ST_DONE
    } state_t;

    // Configuration registers
    window_kind_t              window_kind_reg;
    logic [FRAME_LENGTH_W-1:0] frame_length_reg;
    logic [STEP_W-1:0]         phase_step_reg;
    logic [STEP_W-1:0]         ramp_step_reg;

    // Frame counters
    logic [POS_W-1:0]          position_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic [RAMP_W-1:0]         ramp_reg;
    logic [POS_W-1:0]          position_next;
    logic [PHASE_W-1:0]        phase_next;
    logic [RAMP_W-1:0]         ramp_next;

    // Sequencer and output register
    state_t                    state_reg;
    state_t                    state_next;
    logic                      result_valid_reg;
    logic signed [SAMPLE_BITS-1:0] windowed_reg;
    logic                      frame_end_reg;
    logic                      end_flag_reg;

    // Datapath registers
    window_kind_t              kind_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    // Combinational
    logic                      accept;
    logic                      out_free;
    logic [LEN_W-1:0]          len_raw;
    logic [LEN_W-1:0]          len;
    logic [LEN_W-1:0]          half;
    logic [LEN_W-1:0]          twice_half;
    logic [LEN_W-1:0]          pos_ext;
    logic [LEN_W-1:0]          pos_inc;
    logic                      frame_last;
    logic [RAMP_W-1:0]         rc;
    logic [RAMP_W:0]           ramp_sum;
    logic [RAMP_W-1:0]         ramp_arg;
    logic [RAMP_W:0]           ramp_round;
    logic [GAIN_W-1:0]         bart_gain;
    logic [GAIN_W-1:0]         start_gain;
    logic signed [COS_W-1:0]   cos_value;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [COEF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [GAIN_W-1:0]         gain_base;
    logic signed [COEF_W-1:0]  gain_coef;
    logic signed [PROD_W-1:0]  cos_gain;
    logic signed [PROD_W-1:0]  round_val;
    logic signed [SAMPLE_BITS-1:0] sat_value;

    assign cfg_ready    = 1'b1;
    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign out_free     = !result_valid_reg || result_ready;

    // Cosine table, read at the accept edge with the pre-update phase
    afw_cos_rom #(
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
    ) u_cos_rom (
        .clk      (clk),
        .rd_en    (accept),
        .phase    (phase_reg),
        .cos_value(cos_value)
    );

    // Frame length clamp and position tests
    always_comb
    begin
        len_raw    = LEN_W'(frame_length_reg);
        if (len_raw < LEN_W'(2))
            len = LEN_W'(2);
        else if (len_raw > LEN_W'(MAX_FRAME))
            len = LEN_W'(MAX_FRAME);
        else
            len = len_raw;
        half       = len >> 1;
        twice_half = {half[LEN_W-2:0], 1'b0};
        pos_ext    = LEN_W'(position_reg);
        pos_inc    = pos_ext + LEN_W'(1);
        frame_last = (pos_ext >= (len - LEN_W'(1)));
    end

    // Counter updates
    always_comb
    begin
        rc            = (ramp_reg > RAMP_ONE) ? RAMP_ONE : ramp_reg;
        ramp_sum      = {1'b0, rc} + (RAMP_W+1)'(ramp_step_reg);
        phase_next    = phase_reg + phase_step_reg;
        position_next = POS_W'(pos_inc);
        if (pos_inc == half)
            ramp_next = '0;
        else if (ramp_sum > {1'b0, RAMP_ONE})
            ramp_next = RAMP_ONE;
        else
            ramp_next = ramp_sum[RAMP_W-1:0];
    end

    // Bartlett gain: rising half, falling half, unit on the odd last sample
    always_comb
    begin
        ramp_arg   = (pos_ext < half) ? rc : (RAMP_ONE - rc);
        ramp_round = {1'b0, ramp_arg} + (RAMP_W+1)'(128);
        if (pos_ext < twice_half)
            bart_gain = ramp_round[GAIN_W+7:8];
        else
            bart_gain = GAIN_ONE;
        start_gain = (window_kind_reg == WIN_BARTLETT) ? bart_gain : GAIN_ONE;
    end

    // Shared multiplier operands
    always_comb
    begin
        gain_base = (kind_reg == WIN_HAMMING) ? HAMM_A : HANN_A;
        gain_coef = (kind_reg == WIN_HAMMING) ? HAMM_B_NEG : HANN_B_NEG;
        if (state_reg == ST_GMUL)
        begin
            mul_a = MA_W'(cos_value);
            mul_b = gain_coef;
        end
        else
        begin
            mul_a = MA_W'(sample_reg);
            mul_b = $signed({1'b0, gain_reg});
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Cosine gain is never negative for either coefficient pair
    assign cos_gain = $signed(PROD_W'(gain_base)) + ((prod_reg + ROUND_HALF) >>> 16);

    // Final rounding and saturation
    always_comb
    begin
        round_val = (prod_reg + ROUND_HALF) >>> 16;
        if (round_val > SAT_TOP)
            sat_value = SAT_TOP[SAMPLE_BITS-1:0];
        else if (round_val < SAT_BOT)
            sat_value = SAT_BOT[SAMPLE_BITS-1:0];
        else
            sat_value = round_val[SAMPLE_BITS-1:0];
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (sample_valid) state_next = ST_GMUL;
            ST_GMUL: state_next = ST_GAIN;
            ST_GAIN: state_next = ST_SMUL;
            ST_SMUL: state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State, counters, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_kind_reg  <= WIN_RECT;
            frame_length_reg <= FRAME_LENGTH_RST;
            phase_step_reg   <= PHASE_STEP_RST;
            ramp_step_reg    <= RAMP_STEP_RST;
            position_reg     <= '0;
            phase_reg        <= '0;
            ramp_reg         <= '0;
            end_flag_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            windowed_reg     <= '0;
            frame_end_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_WINDOW_KIND:  window_kind_reg  <= window_kind_t'(cfg_data[1:0]);
                    REG_FRAME_LENGTH: frame_length_reg <= cfg_data[FRAME_LENGTH_W-1:0];
                    REG_PHASE_STEP:   phase_step_reg   <= cfg_data[STEP_W-1:0];
                    REG_RAMP_STEP:    ramp_step_reg    <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                end_flag_reg <= frame_last;
                if (frame_last)
                begin
                    position_reg <= '0;
                    phase_reg    <= '0;
                    ramp_reg     <= '0;
                end
                else
                begin
                    position_reg <= position_next;
                    phase_reg    <= phase_next;
                    ramp_reg     <= ramp_next;
                end
            end

            // output word: load when free, drop when taken
            if (state_reg == ST_DONE && out_free)
            begin
                result_valid_reg <= 1'b1;
                windowed_reg     <= sat_value;
                frame_end_reg    <= end_flag_reg;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= window_kind_reg;
            sample_reg <= sample;
            gain_reg   <= start_gain;
        end
        if (state_reg == ST_GMUL || state_reg == ST_SMUL)
            prod_reg <= mul_p;
        if (state_reg == ST_GAIN && (kind_reg == WIN_HAMMING || kind_reg == WIN_HANN))
            gain_reg <= cos_gain[GAIN_W-1:0];
    end

    assign result_valid    = result_valid_reg;
    assign windowed_sample = windowed_reg;
    assign frame_end       = frame_end_reg;

endmodule

/* rtl/core/afw_cos_rom.sv */
// afw_cos_rom: quarter-wave cosine table with quadrant folding and a registered read.
// Depends on afw_pkg for widths and the Q30 series constants.
module afw_cos_rom #(
    parameter int COS_TABLE_DEPTH = afw_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [afw_pkg::PHASE_W-1:0]       phase,
    output logic signed [afw_pkg::COS_W-1:0]  cos_value
);
    import afw_pkg::*;

    localparam int ADDR_W  = $clog2(COS_TABLE_DEPTH);
    localparam int IDX_W   = $clog2(COS_TABLE_DEPTH + 1);
    localparam int QUART_W = PHASE_W - 1;
    localparam int SCALE_W = QUART_W + IDX_W;
    localparam logic [QUART_W-1:0] QUARTER = QUART_W'(1) << (PHASE_W - 2);

    logic [GAIN_W-1:0]        cos_rom [COS_TABLE_DEPTH];
    logic [1:0]               quad;
    logic [QUART_W-1:0]       q_off;
    logic [QUART_W-1:0]       q_arg;
    logic [SCALE_W-1:0]       scaled;
    logic [IDX_W-1:0]         idx;
    logic [GAIN_W-1:0]        mag;
    logic signed [COS_W-1:0]  signed_mag;
    logic signed [COS_W-1:0]  cos_reg;

    // Constant contents, entry k = cos(pi/2 * k / depth)
    // twelve-term Taylor series in Q30, clamped to [0, 1], rounded to Q1.16
    for (genvar k = 0; k < COS_TABLE_DEPTH; k++)
    begin : g_entry
        localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(k)) / 64'(COS_TABLE_DEPTH);
        localparam logic [63:0] X2    = (ANGLE * ANGLE) >> 30;
        localparam logic [63:0] T1    = ((ONE_Q30 * X2) >> 30) / 64'd2;
        localparam logic [63:0] T2    = ((T1 * X2) >> 30) / 64'd12;
        localparam logic [63:0] T3    = ((T2 * X2) >> 30) / 64'd30;
        localparam logic [63:0] T4    = ((T3 * X2) >> 30) / 64'd56;
        localparam logic [63:0] T5    = ((T4 * X2) >> 30) / 64'd90;
        localparam logic [63:0] T6    = ((T5 * X2) >> 30) / 64'd132;
        localparam logic [63:0] T7    = ((T6 * X2) >> 30) / 64'd182;
        localparam logic [63:0] T8    = ((T7 * X2) >> 30) / 64'd240;
        localparam logic [63:0] T9    = ((T8 * X2) >> 30) / 64'd306;
        localparam logic [63:0] T10   = ((T9 * X2) >> 30) / 64'd380;
        localparam logic [63:0] T11   = ((T10 * X2) >> 30) / 64'd462;
        localparam logic [63:0] T12   = ((T11 * X2) >> 30) / 64'd552;
        localparam longint SUM = longint'(ONE_Q30)
                               - longint'(T1) + longint'(T2) - longint'(T3)
                               + longint'(T4) - longint'(T5) + longint'(T6)
                               - longint'(T7) + longint'(T8) - longint'(T9)
                               + longint'(T10) - longint'(T11) + longint'(T12);
        localparam longint CLAMP = (SUM < 64'sd0) ? 64'sd0 :
                                   ((SUM > longint'(ONE_Q30)) ? longint'(ONE_Q30) : SUM);
        localparam logic [63:0] ROUNDED = (64'(CLAMP) + 64'd8192) >> 14;
        assign cos_rom[k] = ROUNDED[GAIN_W-1:0];
    end

    // Quadrant fold: odd quadrants mirror, middle quadrants negate
    always_comb
    begin
        quad       = phase[PHASE_W-1 -: 2];
        q_off      = {1'b0, phase[PHASE_W-3:0]};
        q_arg      = quad[0] ? (QUARTER - q_off) : q_off;
        scaled     = SCALE_W'(q_arg) * SCALE_W'(COS_TABLE_DEPTH);
        idx        = scaled[PHASE_W-2 +: IDX_W];
        // mirrored index one past the end reads as zero
        mag        = (idx >= IDX_W'(COS_TABLE_DEPTH)) ? '0 : cos_rom[idx[ADDR_W-1:0]];
        signed_mag = $signed({1'b0, mag});
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
            cos_reg <= (quad[0] ^ quad[1]) ? -signed_mag : signed_mag;
    end

    assign cos_value = cos_reg;

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking testbench for audio_frame_window.
// Drives samples and register writes through valid/ready channels, predicts each untyped output
// word with a local fixed-point window model; depends on afw_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;
    import afw_pkg::*;

    localparam int    SAMPLE_W      = 16;
    localparam int    COS_DEPTH     = 256;
    localparam int    LEN_MAX       = 4096;
    localparam int    RANDOM_ITEMS  = 1400;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    SETTLE_CYCLES = 16;
    localparam int    CYCLE_LIMIT   = 400000;
    localparam int    IDLE_PCT      = 31;
    localparam longint UNITY_Q16    = 65536;
    localparam longint UNITY_Q24    = 16777216;
    localparam longint HAMM_OFS_Q16 = 35389;
    localparam longint HAMM_AMP_Q16 = 30147;
    localparam longint HANN_Q16     = 32768;
    localparam logic [63:0] HALF_PI_Q30_C = 64'd1686629713;
    localparam logic [63:0] UNITY_Q30     = 64'd1073741824;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] windowed_sample;
        logic                       frame_end;
    } frame_word_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TYPED,
        ROW_FREE
    } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        cfg_reg_t                   reg_sel;
        logic [CFG_DATA_W-1:0]      data;
        logic signed [SAMPLE_W-1:0] value;
        logic signed [SAMPLE_W-1:0] want;
        logic                       want_end;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          sample_valid;
    logic                          sample_ready;
    logic signed [SAMPLE_W-1:0]    sample;
    logic                          result_valid;
    logic                          result_ready;
    logic signed [SAMPLE_W-1:0]    windowed_sample;
    logic                          frame_end;

    // Local copy of the registers and the frame counters
    window_kind_t                  win_kind;
    logic [FRAME_LENGTH_W-1:0]     win_len;
    logic [STEP_W-1:0]             win_pstep;
    logic [STEP_W-1:0]             win_rstep;
    logic [11:0]                   win_pos;
    logic [PHASE_W-1:0]            win_phase;
    logic [RAMP_W-1:0]             win_ramp;
    longint                        cos_rom [COS_DEPTH];

    frame_word_t                   expected_words [$];
    int                            mismatch_count = 0;
    bit                            calm = 1'b0;
    bit                            hold_req = 1'b0;

    // Directed words: typed results where they are obvious, predictor elsewhere
    stim_row_t dir_rows [38] = '{
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd32767,  16'sd32767,  1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,      -16'sd32768, -16'sd32768,  1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd0,      16'sd0,      1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd1,      16'sd1,      1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,      -16'sd1,     -16'sd1,      1'b0},
        // shrink the frame below the current position: ends at once
        '{ROW_CFG,   REG_FRAME_LENGTH, 24'd2,       16'sd0,      16'sd0,      1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd12345,  16'sd12345,  1'b1},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd100,    16'sd100,    1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd200,    16'sd200,    1'b1},
        // triangle over an odd frame: last word keeps unit gain
        '{ROW_CFG,   REG_WINDOW_KIND,  24'd1,       16'sd0,      16'sd0,      1'b0},
        '{ROW_CFG,   REG_FRAME_LENGTH, 24'd5,       16'sd0,      16'sd0,      1'b0},
        '{ROW_CFG,   REG_RAMP_STEP,    24'd8388608, 16'sd0,      16'sd0,      1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd0,      1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd10000,  1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd20000,  1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd10000,  1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd20000,  1'b1},
        // raised cosine stepping a quarter turn, including the mirrored zero entry
        '{ROW_CFG,   REG_WINDOW_KIND,  24'd3,       16'sd0,      16'sd0,      1'b0},
        '{ROW_CFG,   REG_PHASE_STEP,   24'd4194304, 16'sd0,      16'sd0,      1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd0,      1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd10000,  1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd20000,  1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd10000,  1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd20000,  16'sd0,      1'b1},
        // all-ones data: high bits masked, length clamped to the maximum
        '{ROW_CFG,   REG_WINDOW_KIND,  24'hFFFFFE,  16'sd0,      16'sd0,      1'b0},
        '{ROW_CFG,   REG_FRAME_LENGTH, 24'hFFFFFF,  16'sd0,      16'sd0,      1'b0},
        '{ROW_CFG,   REG_PHASE_STEP,   24'hFFFFFF,  16'sd0,      16'sd0,      1'b0},
        '{ROW_CFG,   REG_RAMP_STEP,    24'hFFFFFF,  16'sd0,      16'sd0,      1'b0},
        '{ROW_TYPED, REG_WINDOW_KIND,  24'd0,       16'sd32767,  16'sd2621,   1'b0},
        '{ROW_FREE,  REG_WINDOW_KIND,  24'd0,      -16'sd32768,  16'sd0,      1'b0},
        '{ROW_FREE,  REG_WINDOW_KIND,  24'd0,       16'sd1,      16'sd0,      1'b0},
        '{ROW_FREE,  REG_WINDOW_KIND,  24'd0,      -16'sd1,      16'sd0,      1'b0},
        // lengths below two clamp up
        '{ROW_CFG,   REG_FRAME_LENGTH, 24'd0,       16'sd0,      16'sd0,      1'b0},
        '{ROW_FREE,  REG_WINDOW_KIND,  24'd0,       16'sd32767,  16'sd0,      1'b0},
        '{ROW_CFG,   REG_FRAME_LENGTH, 24'd1,       16'sd0,      16'sd0,      1'b0},
        '{ROW_CFG,   REG_WINDOW_KIND,  24'hABCD01,  16'sd0,      16'sd0,      1'b0},
        '{ROW_FREE,  REG_WINDOW_KIND,  24'd0,      -16'sd32768,  16'sd0,      1'b0},
        '{ROW_FREE,  REG_WINDOW_KIND,  24'd0,       16'sd32767,  16'sd0,      1'b0}
    };

    audio_frame_window dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .windowed_sample (windowed_sample),
        .frame_end       (frame_end)
    );

    always #1 clk = ~clk;

    // Quarter-wave cosine, Q1.16, from the integer Taylor series
    initial
    begin : cos_rom_fill
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        longint      acc;
        for (int k = 0; k < COS_DEPTH; k++)
        begin
            ang    = (HALF_PI_Q30_C * k) / COS_DEPTH;
            ang_sq = (ang * ang) >> 30;
            term   = UNITY_Q30;
            acc    = UNITY_Q30;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * ang_sq) >> 30) / ((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            if (acc > longint'(UNITY_Q30))
                acc = UNITY_Q30;
            cos_rom[k] = (acc + 8192) >>> 14;
        end
    end

    function automatic longint rom_read(input logic [22:0] quarter_phase);
        longint idx;
        idx = (longint'(quarter_phase) * COS_DEPTH) >>> 22;
        if (idx >= COS_DEPTH)
            return 0;
        return cos_rom[idx];
    endfunction

    // Full-turn cosine: top two phase bits pick the quadrant
    function automatic longint phase_cos(input logic [PHASE_W-1:0] ph);
        logic [22:0] q;
        q = {1'b0, ph[21:0]};
        case (ph[23:22])
            2'd0:    return rom_read(q);
            2'd1:    return -rom_read(23'h400000 - q);
            2'd2:    return -rom_read(q);
            default: return rom_read(23'h400000 - q);
        endcase
    endfunction

    // Output word for one sample; advances the frame counters
    function automatic frame_word_t predict_frame_word(input logic signed [SAMPLE_W-1:0] smp);
        frame_word_t word;
        longint      len;
        longint      half;
        longint      rc;
        longint      gain;
        longint      g32;
        longint      prod;
        longint      res;
        longint      next_ramp;
        logic        last;
        len = win_len;
        if (len < 2)
            len = 2;
        if (len > LEN_MAX)
            len = LEN_MAX;
        half = len >> 1;
        rc   = (win_ramp > UNITY_Q24) ? UNITY_Q24 : longint'(win_ramp);

        case (win_kind)
            WIN_BARTLETT:
            begin
                if (win_pos < half)
                    gain = (rc + 128) >>> 8;
                else if (win_pos < 2 * half)
                    gain = (UNITY_Q24 - rc + 128) >>> 8;
                else
                    gain = UNITY_Q16;
            end
            WIN_HAMMING, WIN_HANN:
            begin
                if (win_kind == WIN_HAMMING)
                    g32 = HAMM_OFS_Q16 * UNITY_Q16 - HAMM_AMP_Q16 * phase_cos(win_phase);
                else
                    g32 = HANN_Q16 * UNITY_Q16 - HANN_Q16 * phase_cos(win_phase);
                if (g32 < 0)
                    g32 = 0;
                gain = (g32 + 32768) >>> 16;
            end
            default:
                gain = UNITY_Q16;
        endcase

        // round half up, then saturate
        prod = longint'(smp) * gain;
        res  = (prod + 32768) >>> 16;
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;

        last = (longint'(win_pos) >= len - 1);
        if (last)
        begin
            win_pos   = '0;
            win_phase = '0;
            win_ramp  = '0;
        end
        else
        begin
            win_phase = win_phase + win_pstep;
            next_ramp = rc + longint'(win_rstep);
            if (longint'(win_pos) + 1 == half)
                win_ramp = '0;
            else
                win_ramp = (next_ramp > UNITY_Q24) ? RAMP_W'(UNITY_Q24) : RAMP_W'(next_ramp);
            win_pos = win_pos + 1'b1;
        end

        word.windowed_sample = res[SAMPLE_W-1:0];
        word.frame_end       = last;
        return word;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Register write; cfg_valid is dropped before the task returns so the next write starts clean
    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (sel)
            REG_WINDOW_KIND:  win_kind  = window_kind_t'(value[1:0]);
            REG_FRAME_LENGTH: win_len   = value[FRAME_LENGTH_W-1:0];
            REG_PHASE_STEP:   win_pstep = value;
            default:          win_rstep = value;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one sample word; the expectation is queued on acceptance
    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] value, input row_kind_t how,
                                input logic signed [SAMPLE_W-1:0] want, input logic want_end);
        frame_word_t word;
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
            end
        sample_valid <= 1'b1;
        sample       <= value;
        do @(posedge clk); while (!sample_ready);
        word = predict_frame_word(value);
        if (how == ROW_TYPED)
        begin
            word.windowed_sample = want;
            word.frame_end       = want_end;
        end
        expected_words.push_back(word);
    endtask

    // Stop offering and wait for every outstanding word
    task automatic wait_drain();
        sample_valid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin : result_sink
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        frame_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", windowed_sample, 0);
            else
            begin
                want = expected_words.pop_front();
                if (windowed_sample !== want.windowed_sample)
                    report_mismatch("windowed_sample", windowed_sample, want.windowed_sample);
                if (frame_end !== want.frame_end)
                    report_mismatch("frame_end", frame_end, want.frame_end);
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[audio_frame_window] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int                         phase_no;
        int                         items_left;
        int                         burst;
        int                         roll;
        longint                     eff_len;
        logic [FRAME_LENGTH_W-1:0]  len_raw;
        logic [CFG_DATA_W-1:0]      kind_data;
        logic [CFG_DATA_W-1:0]      len_data;
        logic [STEP_W-1:0]          pstep;
        logic [STEP_W-1:0]          rstep;
        logic signed [SAMPLE_W-1:0] smp;

        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_WINDOW_KIND;
        cfg_data     <= '0;
        sample_valid <= 1'b0;
        sample       <= '0;
        win_kind     = WIN_RECT;
        win_len      = FRAME_LENGTH_RST;
        win_pstep    = PHASE_STEP_RST;
        win_rstep    = RAMP_STEP_RST;
        win_pos      = '0;
        win_phase    = '0;
        win_ramp     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_drain();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].data);
            end
            else
                offer_sample(dir_rows[i].value, dir_rows[i].kind,
                             dir_rows[i].want, dir_rows[i].want_end);
        end

        // Random phases, each with its own register setting
        items_left = RANDOM_ITEMS;
        phase_no   = 0;
        while (items_left > 0)
        begin
            wait_drain();

            roll = $urandom_range(99);
            if (roll < 60)
                len_raw = FRAME_LENGTH_W'($urandom_range(2, 24));
            else if (roll < 85)
                len_raw = FRAME_LENGTH_W'($urandom_range(25, 200));
            else if (roll < 93)
                case ($urandom_range(3))
                    0:       len_raw = 13'd0;
                    1:       len_raw = 13'd1;
                    2:       len_raw = 13'd4095;
                    default: len_raw = 13'd4096;
                endcase
            else
                len_raw = FRAME_LENGTH_W'($urandom_range(0, 8191));
            eff_len = (len_raw < 2) ? 2 : ((len_raw > LEN_MAX) ? LEN_MAX : len_raw);

            // matching reciprocals mostly, otherwise anything
            pstep = (eff_len == 2) ? 24'hFFFFFF : STEP_W'(UNITY_Q24 / (eff_len - 1));
            rstep = ((eff_len >> 1) == 1) ? 24'hFFFFFF : STEP_W'(UNITY_Q24 / (eff_len >> 1));
            roll  = $urandom_range(99);
            if (roll < 12)
                pstep = STEP_W'($urandom);
            else if (roll < 16)
                pstep = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
            roll = $urandom_range(99);
            if (roll < 12)
                rstep = STEP_W'($urandom);
            else if (roll < 16)
                rstep = $urandom_range(1) ? 24'hFFFFFF : 24'h0;

            kind_data      = CFG_DATA_W'($urandom);
            kind_data[1:0] = 2'($urandom_range(3));
            len_data       = CFG_DATA_W'($urandom);
            if ($urandom_range(99) >= 20)
                len_data[CFG_DATA_W-1:FRAME_LENGTH_W] = '0;
            len_data[FRAME_LENGTH_W-1:0] = len_raw;

            if ($urandom_range(99) < 65)
            begin
                write_reg(REG_WINDOW_KIND, kind_data);
                write_reg(REG_FRAME_LENGTH, len_data);
                write_reg(REG_PHASE_STEP, pstep);
                write_reg(REG_RAMP_STEP, rstep);
            end
            else
            begin
                if ($urandom_range(1))
                    write_reg(REG_WINDOW_KIND, kind_data);
                if ($urandom_range(1))
                    write_reg(REG_FRAME_LENGTH, len_data);
                if ($urandom_range(1))
                    write_reg(REG_PHASE_STEP, pstep);
                if ($urandom_range(1))
                    write_reg(REG_RAMP_STEP, rstep);
            end

            // phases 3 and 7: no idling on either side; phase 7 also: long output hold-off
            calm  = (phase_no == 3) || (phase_no == 7);
            burst = calm ? 150 : $urandom_range(20, 110);
            if (burst > items_left)
                burst = items_left;
            if (phase_no == 7)
                hold_req = 1'b1;

            for (int j = 0; j < burst; j++)
            begin
                if (phase_no == 5 && j == burst / 2)
                    wait_drain();
                roll = $urandom_range(99);
                if (roll < 8)
                    smp = 16'sh7FFF;
                else if (roll < 16)
                    smp = 16'sh8000;
                else if (roll < 22)
                    smp = SAMPLE_W'($urandom_range(4)) - 16'sd2;
                else
                    smp = SAMPLE_W'($urandom);
                offer_sample(smp, ROW_FREE, 16'sd0, 1'b0);
            end
            items_left = items_left - burst;
            phase_no++;
        end
        calm = 1'b0;

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch("words still outstanding", expected_words.size(), 0);

        if (mismatch_count == 0)
            $display("[audio_frame_window] OK");
        else
            $display("[audio_frame_window] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/afw_pkg.sv
rtl/core/afw_cos_rom.sv
rtl/core/audio_frame_window.sv
verif/tb_top.sv
